// ===== hdl/htfd_pkg.sv =====
package htfd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned RAW_W     = 20;
  localparam int unsigned HUM_W     = 7;
  localparam int unsigned TEMP_W    = 9;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned BUSY_BIT  = 7;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

  // byte positions inside a frame
  localparam logic [IDX_W-1:0] IDX_IDLE  = 3'd0;
  localparam logic [IDX_W-1:0] IDX_FIRST = 3'd1;
  localparam logic [IDX_W-1:0] IDX_CRC   = 3'd6;

  // scaling with round-half-up before dropping the 20 fraction bits
  localparam logic [27:0] ROUND_HALF = 28'h0080000;
  localparam logic [6:0]  HUM_SCALE  = 7'd100;
  localparam logic [7:0]  TEMP_SCALE = 8'd200;
  localparam logic signed [TEMP_W-1:0] TEMP_OFFS = 9'sd50;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_CRC  = 2'd2
  } status_t;

  typedef struct packed {
    status_t                    status;
    logic [HUM_W-1:0]           hum;
    logic signed [TEMP_W-1:0]   temp;
    logic                       valid;
  } result_t;

  // crc-8, msb first, one byte
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/htfd_scale.sv =====
module htfd_scale import htfd_pkg::*; (
  input  logic [2*RAW_W-1:0]       raw,
  output logic [HUM_W-1:0]         hum,
  output logic signed [TEMP_W-1:0] temp
);

  logic [RAW_W-1:0] raw_h;
  logic [RAW_W-1:0] raw_t;
  logic [27:0]      hum_prod;
  logic [27:0]      temp_prod;
  logic [7:0]       temp_pos;

  assign raw_h = raw[2*RAW_W-1:RAW_W];
  assign raw_t = raw[RAW_W-1:0];

  // products stay below 2^28 with the rounding term added
  assign hum_prod  = {8'd0, raw_h} * {21'd0, HUM_SCALE} + ROUND_HALF;
  assign temp_prod = {8'd0, raw_t} * {20'd0, TEMP_SCALE} + ROUND_HALF;

  assign hum      = hum_prod[RAW_W +: HUM_W];
  assign temp_pos = temp_prod[RAW_W +: 8];
  assign temp     = $signed({1'b0, temp_pos}) - TEMP_OFFS;

endmodule

// ===== hdl/htfd_frame.sv =====
module htfd_frame import htfd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] frame_byte,
  input  logic              frame_start,
  output logic              is_last,
  output result_t           result
);

  logic [IDX_W-1:0]         idx_r;
  logic [BYTE_W-1:0]        crc_r;
  logic                     busy_r;
  logic [2*RAW_W-1:0]       raw_r;
  logic [HUM_W-1:0]         hum_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic                     valid_r;

  logic                     first;
  logic                     good;
  logic [BYTE_W-1:0]        crc_nxt;
  logic [HUM_W-1:0]         hum_scaled;
  logic signed [TEMP_W-1:0] temp_scaled;

  // a start flag or an idle counter makes this the status byte
  assign first   = frame_start || (idx_r == IDX_IDLE);
  assign is_last = !first && (idx_r == IDX_CRC);
  assign crc_nxt = crc8_byte(first ? CRC_INIT : crc_r, frame_byte);
  assign good    = is_last && !busy_r && (crc_r == frame_byte);

  htfd_scale u_scale (
    .raw  (raw_r),
    .hum  (hum_scaled),
    .temp (temp_scaled)
  );

  always_comb begin
    if (busy_r) begin
      result.status = ST_BUSY;
    end else if (crc_r != frame_byte) begin
      result.status = ST_CRC;
    end else begin
      result.status = ST_OK;
    end
    result.hum   = good ? hum_scaled : hum_r;
    result.temp  = good ? temp_scaled : temp_r;
    result.valid = good || valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= IDX_IDLE;
      crc_r   <= CRC_INIT;
      busy_r  <= 1'b0;
      hum_r   <= '0;
      temp_r  <= '0;
      valid_r <= 1'b0;
    end else if (step) begin
      if (first) begin
        idx_r  <= IDX_FIRST;
        crc_r  <= crc_nxt;
        busy_r <= frame_byte[BUSY_BIT];
      end else if (is_last) begin
        idx_r <= IDX_IDLE;
        crc_r <= CRC_INIT;
        if (good) begin
          hum_r   <= hum_scaled;
          temp_r  <= temp_scaled;
          valid_r <= 1'b1;
        end
      end else begin
        idx_r <= idx_r + IDX_FIRST;
        crc_r <= crc_nxt;
      end
    end
  end

  // five data bytes fill the whole field word, so no clear is needed
  always_ff @(posedge clk) begin
    if (step && !first && !is_last) begin
      raw_r <= {raw_r[2*RAW_W-BYTE_W-1:0], frame_byte};
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_CRC)
    else $error("byte counter past crc position");

  a_idle_after_crc: assert property (@(posedge clk) disable iff (!rst_n)
    step && is_last |=> idx_r == IDX_IDLE && crc_r == CRC_INIT)
    else $error("frame state not restarted after crc byte");

  a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> valid_r)
    else $error("reading valid flag dropped");

endmodule

// ===== hdl/humidity_temp_frame_decoder_core.sv =====
// Decodes a seven-byte humidity/temperature measurement frame.
// Input stream: one frame byte per transaction in in_tdata; in_tuser set on
// the first byte restarts the frame. A byte arriving with no frame in progress
// is taken as the status byte all the same.
// Output stream: one transaction per seventh (crc) byte carrying the status
// code (ok, busy, crc mismatch), the last good humidity in percent, the last
// good temperature in degrees C and the reading-valid flag. A bad frame
// reports the previously held readings.
// Path: a crc byte goes through the input register, then the decode logic
// into the result register, before it shows on out_tvalid.
// Throughput: one byte per cycle, unless a crc byte waits on a pending result.
// Stall: when out_tready is low with a result pending, data bytes keep
// flowing; only a crc byte waits in the input register, and in_tready drops
// until the result register is free.
// Reset: clears the frame counter, crc, held readings and valid flag; no
// transaction is pending afterwards.
module humidity_temp_frame_decoder_core import htfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [1:0] status, [8:2] humidity_pct,
                                  // [17:9] temperature_c, [18] reading_valid
);

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_start_r;
  logic              out_valid_r;
  result_t           out_res_r;

  logic              out_free;
  logic              s1_adv;
  logic              is_last;
  result_t           result;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!is_last || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  htfd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_adv),
    .frame_byte  (s1_byte_r),
    .frame_start (s1_start_r),
    .is_last     (is_last),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && is_last) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.valid, out_res_r.temp, out_res_r.hum,
                       out_res_r.status};

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && is_last |-> !out_valid_r || out_tready)
    else $error("result register overwritten while pending");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_start_r))
    else $error("stalled input byte lost");

  a_ok_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status == ST_OK |-> out_res_r.valid)
    else $error("ok status without valid reading");

endmodule
